@@ src/jitter_buffer_ring_fifo_assert.svh @@
// assertion macros for the jitter buffer ring fifo
// no dependencies; included by the top level only
`ifndef JITTER_BUFFER_RING_FIFO_ASSERT_SVH
`define JITTER_BUFFER_RING_FIFO_ASSERT_SVH

`ifndef SYNTH

`define JBRF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

`define JBRF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next cycle check failed");

`else

`define JBRF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define JBRF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/jbrf_pkg.sv @@
// shared constants, types and pointer helpers for the jitter buffer ring fifo
// no dependencies
package jbrf_pkg;

  localparam int DEPTH    = 16;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W   = 32;
  localparam int THR_W    = 4;
  localparam int FILL_W   = 4;
  localparam int FILL_MAX = (1 << FILL_W) - 1;
  localparam int CMP_W    = (PTR_W > FILL_W) ? PTR_W + 1 : FILL_W + 1;
  localparam int FULL_LVL = ((DEPTH - 1) > FILL_MAX) ? FILL_MAX : (DEPTH - 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FULL_LVL);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BUFFERING = 2'd3
  } status_e;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic              success;
    status_e           status;
    logic              pulled;
    logic [FILL_W-1:0] fill;
  } res_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] nxt;
    if (CMP_W'(idx) == CMP_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + PTR_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] wr,
                                                input logic [PTR_W-1:0] rd);
    logic [CMP_W-1:0] f;
    if (wr >= rd) begin
      f = CMP_W'(wr) - CMP_W'(rd);
    end else begin
      f = CMP_W'(wr) + CMP_W'(DEPTH) - CMP_W'(rd);
    end
    if (f > CMP_W'(FILL_MAX)) begin
      f = CMP_W'(FILL_MAX);
    end
    return FILL_W'(f);
  endfunction

endpackage

@@ src/jbrf_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module jbrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/jbrf_ctrl.sv @@
// pointer, buffering gate and threshold control for the ring fifo
// depends on jbrf_pkg
module jbrf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      operation_i,
  input  logic                      cfg_we_i,
  input  logic [jbrf_pkg::THR_W-1:0] cfg_data_i,
  output jbrf_pkg::mem_req_t        mem_req_o,
  output jbrf_pkg::res_t            res_o
);
  import jbrf_pkg::*;

  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic             buf_q, buf_d;
  logic [THR_W-1:0] thr_q;
  res_t             res_q, res_d;
  logic [PTR_W-1:0] nxt_w;
  logic             full, empty, below;
  logic [FILL_W-1:0] fill_now;

  assign nxt_w    = next_slot(wr_q);
  assign full     = (nxt_w == rd_q);
  assign empty    = (wr_q == rd_q);
  assign fill_now = fill_of(wr_q, rd_q);
  assign below    = (fill_now < thr_q);

  always_comb begin
    wr_d          = wr_q;
    rd_d          = rd_q;
    buf_d         = buf_q;
    mem_req_o     = '0;
    res_d         = '0;
    res_d.status  = ST_OK;
    if (accept_i) begin
      res_d.valid = 1'b1;
      case (op_e'(operation_i))
        OP_PUSH: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = wr_q;
            wr_d            = nxt_w;
            res_d.success   = 1'b1;
          end
        end
        OP_PULL: begin
          if (empty) begin
            buf_d        = 1'b1;
            res_d.status = ST_EMPTY;
          end else if (buf_q && below) begin
            res_d.status = ST_BUFFERING;
          end else begin
            buf_d           = 1'b0;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = rd_q;
            rd_d            = next_slot(rd_q);
            res_d.success   = 1'b1;
            res_d.pulled    = 1'b1;
          end
        end
        default: begin
          res_d.status = ST_OK;
        end
      endcase
    end
    res_d.fill = fill_of(wr_d, rd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      buf_q <= 1'b1;
      thr_q <= THR_RESET;
      res_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      buf_q <= buf_d;
      res_q <= res_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  assign res_o = res_q;

endmodule

@@ src/jitter_buffer_ring_fifo.sv @@
// results: each result strobes in the cycle after its transfer is taken
// throughput: one item per cycle, set by the single ram write and read port
// busy stays low; the receiver cannot stall and needs no backpressure
// reset: pointers cleared, buffering on, threshold back to 8; ring contents kept
// depends on jbrf_pkg, jbrf_ctrl, jbrf_ram and the assertion header
module jitter_buffer_ring_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic signed [31:0]          packet_word_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [jbrf_pkg::THR_W-1:0]  cfg_data_i,
  output logic                        done_o,
  output logic                        success_o,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          pulled_word_o,
  output logic [jbrf_pkg::FILL_W-1:0] fill_level_o
);
  import jbrf_pkg::*;

  `include "jitter_buffer_ring_fifo_assert.svh"

  logic              accept;
  mem_req_t          mem_req;
  res_t              res;
  logic [WORD_W-1:0] rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  jbrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .res_o       (res)
  );

  jbrf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (packet_word_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  assign done_o        = res.valid;
  assign success_o     = res.success;
  assign status_o      = res.status;
  assign fill_level_o  = res.fill;
  assign pulled_word_o = res.pulled ? $signed(rdata) : '0;

  `JBRF_ASSERT_NXT(a_result_follows, clk_i, rst_ni, accept, done_o)
  `JBRF_ASSERT_IMP(a_success_ok, clk_i, rst_ni, done_o && success_o, status_o == ST_OK)
  `JBRF_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && !success_o, pulled_word_o == '0)
  `JBRF_ASSERT_IMP(a_full_level, clk_i, rst_ni, done_o && status_o == ST_FULL,
                   fill_level_o == FILL_FULL)

endmodule

@@ bench/jitter_buffer_ring_fifo_tb.sv @@
// testbench for the jitter buffer ring fifo: directed corners, then random push and pull
// traffic under several playout thresholds, checked against an in-bench playout model
// depends on jbrf_pkg and the jitter_buffer_ring_fifo rtl
`timescale 1ns / 100ps

module jitter_buffer_ring_fifo_tb;
  import jbrf_pkg::*;

  localparam int STALL_LIMIT    = 500;
  localparam int RANDOM_PHASES  = 12;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic               success;
    status_e            status;
    logic signed [31:0] word;
    logic [FILL_W-1:0]  fill;
  } playout_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     operation_i = 1'b0;
  logic signed [31:0]       packet_word_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [THR_W-1:0]         cfg_data_i = '0;
  logic                     done_o;
  logic                     success_o;
  logic [1:0]               status_o;
  logic signed [31:0]       pulled_word_o;
  logic [FILL_W-1:0]        fill_level_o;

  // playout model state
  logic [31:0]              ring_copy [DEPTH];
  int                       wr_ptr = 0;
  int                       rd_ptr = 0;
  logic                     buffering = 1'b1;
  logic [THR_W-1:0]         threshold = THR_RESET;

  playout_result_t          pending_results [$];
  int                       errors = 0;
  int                       items_taken = 0;
  int                       threshold_writes = 0;
  int                       status_seen [4] = '{0, 0, 0, 0};
  int                       stall_cycles = 0;
  bit                       gaps_on = 1'b1;

  jitter_buffer_ring_fifo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .packet_word_i (packet_word_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .success_o     (success_o),
    .status_o      (status_o),
    .pulled_word_o (pulled_word_o),
    .fill_level_o  (fill_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int words_held();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic playout_result_t predict_playout(input op_e op,
                                                      input logic [31:0] word);
    playout_result_t r;
    int nxt;
    r = '0;
    if (op == OP_PUSH) begin
      nxt = (wr_ptr + 1) % DEPTH;
      if (nxt == rd_ptr) begin
        r.status = ST_FULL;
      end else begin
        ring_copy[PTR_W'(wr_ptr)] = word;
        wr_ptr = nxt;
        r.success = 1'b1;
      end
    end else if (wr_ptr == rd_ptr) begin
      buffering = 1'b1;
      r.status = ST_EMPTY;
    end else if (buffering && words_held() < int'(threshold)) begin
      r.status = ST_BUFFERING;
    end else begin
      buffering = 1'b0;
      r.word = ring_copy[PTR_W'(rd_ptr)];
      rd_ptr = (rd_ptr + 1) % DEPTH;
      r.success = 1'b1;
    end
    r.fill = (words_held() > FILL_MAX) ? FILL_FULL : FILL_W'(words_held());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // result check, then prediction of the item taken at this edge
  always @(posedge clk_i) begin : result_check
    playout_result_t want;
    if (rst_ni) begin
      stall_cycles++;
      if (done_o) begin
        stall_cycles = 0;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", pulled_word_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (success_o !== want.success) begin
            report_mismatch("success", 32'(success_o), 32'(want.success));
          end
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
          if (pulled_word_o !== want.word) report_mismatch("pulled_word", pulled_word_o, want.word);
          if (fill_level_o !== want.fill) begin
            report_mismatch("fill_level", 32'(fill_level_o), 32'(want.fill));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        stall_cycles = 0;
        threshold = cfg_data_i;
        threshold_writes++;
      end
      if (start && !busy) begin
        stall_cycles = 0;
        want = predict_playout(op_e'(operation_i), packet_word_i);
        status_seen[want.status]++;
        pending_results.insert(pending_results.size(), want);
        items_taken++;
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("FAIL jitter_buffer_ring_fifo");
    $finish;
  end

  // start stays high after a transfer so back-to-back items need no second drive
  task automatic send_item(input op_e op, input logic [31:0] word);
    start <= 1'b1;
    operation_i <= op;
    packet_word_i <= word;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_corners();
    // underflow at reset, then pulls held back below the reset threshold
    send_item(OP_PULL, 32'h0000_0000);
    send_item(OP_PUSH, 32'h7fff_ffff);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PULL, 32'hffff_ffff);
    // zero threshold plays out at once, then underflows
    write_threshold('0);
    send_item(OP_PULL, 32'h0000_0000);
    send_item(OP_PULL, 32'h0000_0000);
    send_item(OP_PULL, 32'h0000_0000);
    // top threshold needs a full ring; one more push overflows
    write_threshold('1);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'hffff_ffff);
    send_item(OP_PUSH, 32'haaaa_aaaa);
    send_item(OP_PUSH, 32'h5555_5555);
    for (int i = 4; i < DEPTH - 1; i++) begin
      send_item(OP_PULL, $urandom);
      send_item(OP_PUSH, $urandom);
    end
    send_item(OP_PUSH, 32'h1234_5678);
    send_item(OP_PULL, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int push_pct;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_threshold('0);
        1:       write_threshold('1);
        2:       write_threshold(THR_W'(1));
        default: write_threshold(THR_W'($urandom_range(0, 15)));
      endcase
      gaps_on = (p < RANDOM_PHASES - 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // alternate filling, draining and balanced stretches
        case ((i / 25) % 3)
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_PULL, $urandom);
        maybe_gap();
      end
    end
  endtask

  initial begin : sequencer
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_traffic();
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never seen", 32'(pending_results.size()), '0);
    end
    $display("covered %0d items under %0d threshold settings", items_taken, threshold_writes);
    $display("outcomes: %0d ok, %0d overflow, %0d underflow, %0d held back",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BUFFERING]);
    if (errors == 0) begin
      $display("PASS jitter_buffer_ring_fifo");
    end else begin
      $display("FAIL jitter_buffer_ring_fifo");
    end
    $finish;
  end

endmodule

@@ jitter_buffer_ring_fifo.f @@
+incdir+src
src/jbrf_pkg.sv
src/jbrf_ram.sv
src/jbrf_ctrl.sv
src/jitter_buffer_ring_fifo.sv
bench/jitter_buffer_ring_fifo_tb.sv
